>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dbc_pkg.sv
// Package with the constants, types and tables of the device-bus controller.
`timescale 1ns / 1ps
package dbc_pkg;

    localparam int CHIP_SELECTS = 8;
    localparam int CS_W = (CHIP_SELECTS > 1) ? $clog2(CHIP_SELECTS) : 1;
    localparam int NREGS = 15;

    localparam logic [3:0] IDX_CTRL = 4'd10;
    localparam logic [3:0] IDX_WIN = 4'd11;
    localparam logic [3:0] IDX_NONE = 4'd15;

    localparam int BIT_PROG = 48;
    localparam int BIT_MAP = 40;
    localparam int BIT_STOP = 32;
    localparam int BIT_BOOTROM = 30;
    localparam int BIT_TIMEOUT = 29;

    localparam logic [1:0] CFG_BOOT_DEV = 2'd0;
    localparam logic [1:0] CFG_DEVICES = 2'd1;
    localparam logic [1:0] CFG_WD_TICKS = 2'd2;

    localparam logic [31:0] WD_TICKS_RESET = 32'd50000000;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_TICK   = 2'd2,
        OP_DECODE = 2'd3
    } t_opcode;

    localparam logic [63:0] WMASK [NREGS] = '{
        64'h0000000000000000, 64'h00000000FFFFFFFF,
        64'h007F3F3F3F3F3FFF, 64'h007F3F3F3F3F3FFF,
        64'h007F3F3F3F3F3FFF, 64'h007F3F3F3F3F3FFF,
        64'h007F3F3F3F3F3FFF, 64'h007F3F3F3F3F3FFF,
        64'h007F3F3F3F3F3FFF, 64'h007F3F3F3F3F3FFF,
        64'h0701000000000000,
        64'h1FFF1FFF1FFF1FFF, 64'h1FFF1FFF1FFF1FFF,
        64'h1FFF1FFF1FFF1FFF, 64'h1FFF1FFF1FFF1FFF
    };

    localparam logic [63:0] RSTVAL [NREGS] = '{
        64'h0000000000000F00, 64'h0000000002020202,
        64'h0001000400070304, 64'h0001000400070304,
        64'h0001000400070304, 64'h0001000400070304,
        64'h0001000400070304, 64'h0001000400070304,
        64'h0001000400070304, 64'h0001000400070304,
        64'h0000010000000000,
        64'h1FFF1FFF00000000, 64'h1FFF1FFF1FFF1FFF,
        64'h1FFF1FFF1FFF1FFF, 64'h1FFF1FFF1FFF1FFF
    };

endpackage

>>> rtl/dbc_if.sv
// Handshake interfaces for the request, response and configuration channels.
`timescale 1ns / 1ps
interface dbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [6:0]  reg_addr;
    logic [63:0] write_data;
    logic        word_access;
    logic [28:0] outer_addr;

    modport source (output valid, opcode, reg_addr, write_data, word_access, outer_addr,
                    input ready);
    modport sink (input valid, opcode, reg_addr, write_data, word_access, outer_addr,
                  output ready);
endinterface

interface dbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic        out_of_range;
    logic        boot_map_enabled;
    logic        reboot_request;
    logic        cs_hit;
    logic [2:0]  cs_index;

    modport source (output valid, read_data, out_of_range, boot_map_enabled,
                    reboot_request, cs_hit, cs_index, input ready);
    modport sink (input valid, read_data, out_of_range, boot_map_enabled,
                  reboot_request, cs_hit, cs_index, output ready);
endinterface

interface dbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/dbc_cs_match.sv
// Window compare unit that tests one chip select against an outer-window offset.
`timescale 1ns / 1ps
module dbc_cs_match
    import dbc_pkg::*;
(
    input  logic [31:0] i_window,
    input  logic        i_present,
    input  logic [28:0] i_addr,
    output logic        o_hit
);

    logic [12:0] base_f;
    logic [12:0] mask_f;
    logic [13:0] span;
    logic [13:0] low_bit;
    logic [29:0] size;
    logic [29:0] diff;

    assign base_f  = i_window[12:0];
    assign mask_f  = i_window[28:16];
    assign span    = {1'b1, base_f | mask_f};
    assign low_bit = span & (~span + 14'd1);
    assign size    = {low_bit, 16'd0};
    assign diff    = {1'b0, i_addr} - {1'b0, base_f, 16'd0};
    assign o_hit   = i_present && (mask_f >= base_f) && !diff[29] && (diff < size);

endmodule

>>> rtl/device_bus_controller_regs.sv
// Top level of the device-bus controller: register file, boot watchdog and chip-select decode.
//
// Requests arrive on i_req (valid/ready); each gives exactly one response on o_rsp.
// Opcodes: register read, register write, watchdog tick, outer-window address decode.
// Configuration writes arrive on i_cfg, are always taken, and must only be issued
// while no request is in flight.
// The block works on one request at a time. A read, write or tick is accepted in
// S_IDLE, moves to S_FINISH and has its response registered once the output register is free.
// A decode walks the chip selects in order through one shared window compare unit,
// one chip select per cycle, stopping at the first hit, before it moves to S_FINISH.
// The response waits in the output register while the receiver stalls; a finished
// request is held back until that register is free, and a new request is taken
// as soon as the previous response has been loaded.
// Reset loads the fixed register values, the default watchdog length and clears
// the boot strap, so the boot alias is unmapped and the watchdog is disarmed.
`timescale 1ns / 1ps
module device_bus_controller_regs
    import dbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbc_cfg_if.sink   i_cfg,
    dbc_req_if.sink   i_req,
    dbc_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_FINISH
    } t_state;

    t_state      r_state;
    logic [63:0] r_rf [NREGS];
    logic [7:0]  r_devices;
    logic [31:0] r_wd_ticks;
    logic [31:0] r_wd_count;
    logic        r_wd_armed;
    logic        r_mapped;

    t_opcode     r_op;
    logic [3:0]  r_idx;
    logic        r_upper;
    logic        r_word;
    logic [63:0] r_wdata;
    logic [28:0] r_oaddr;
    logic [CS_W-1:0] r_cs;
    logic        r_hit;

    logic        r_out_valid;
    logic [63:0] r_out_rdata;
    logic        r_out_oor;
    logic        r_out_mapped;
    logic        r_out_reboot;
    logic        r_out_hit;
    logic [2:0]  r_out_csi;

    logic [3:0]  rd_idx;
    logic [63:0] rf_rd;
    logic [31:0] win_half;
    logic        cs_match;
    logic        out_free;
    logic        oor;
    logic [63:0] wmask;
    logic [63:0] wr_val;
    logic [63:0] n_reg;
    logic [63:0] n_ctrl;
    logic [63:0] rd_val;
    logic [63:0] ctrl;
    logic [63:0] n_tick_ctrl;
    logic [63:0] n_strap_ctrl;
    logic [63:0] n_out_rdata;
    logic        n_out_oor;
    logic        n_out_mapped;
    logic        n_out_reboot;
    logic        n_out_hit;
    logic [2:0]  n_out_csi;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out_rdata;
    assign o_rsp.out_of_range     = r_out_oor;
    assign o_rsp.boot_map_enabled = r_out_mapped;
    assign o_rsp.reboot_request   = r_out_reboot;
    assign o_rsp.cs_hit           = r_out_hit;
    assign o_rsp.cs_index         = r_out_csi;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign oor      = (r_idx == IDX_NONE);
    assign rd_idx   = (r_state == S_DECODE) ? IDX_WIN + 4'(r_cs >> 1) : r_idx;
    assign rf_rd    = r_rf[rd_idx];
    assign ctrl     = r_rf[IDX_CTRL];
    assign win_half = r_cs[0] ? rf_rd[63:32] : rf_rd[31:0];

    dbc_cs_match u_match (
        .i_window (win_half),
        .i_present(r_devices[r_cs]),
        .i_addr   (r_oaddr),
        .o_hit    (cs_match)
    );

    always_comb begin
        wmask = oor ? 64'd0 : WMASK[r_idx];
        if (r_word) begin
            wr_val = r_upper ? {r_wdata[31:0], rf_rd[31:0]} : {rf_rd[63:32], r_wdata[31:0]};
        end else begin
            wr_val = r_wdata;
        end
        n_reg  = (rf_rd & ~wmask) | (wr_val & wmask);
        n_ctrl = n_reg;
        if (n_reg[BIT_BOOTROM]) begin
            if (!wr_val[BIT_MAP] && n_reg[BIT_STOP]) begin
                n_ctrl[BIT_MAP] = 1'b0;
            end
            if (wr_val[BIT_STOP] && !n_reg[BIT_TIMEOUT]) begin
                n_ctrl[BIT_STOP] = 1'b1;
            end
        end
        if (oor) begin
            rd_val = '1;
        end else if (r_word) begin
            rd_val = {32'd0, r_upper ? rf_rd[63:32] : rf_rd[31:0]};
        end else begin
            rd_val = rf_rd;
        end

        n_tick_ctrl = ctrl;
        n_tick_ctrl[BIT_MAP] = 1'b0;
        n_tick_ctrl[BIT_TIMEOUT] = 1'b1;
        n_strap_ctrl = ctrl;
        n_strap_ctrl[BIT_BOOTROM] = i_cfg.data[0];
        if (i_cfg.data[0]) begin
            n_strap_ctrl[BIT_MAP] = 1'b1;
        end

        n_out_rdata  = 64'd0;
        n_out_oor    = 1'b0;
        n_out_mapped = r_mapped;
        n_out_reboot = 1'b0;
        n_out_hit    = 1'b0;
        n_out_csi    = 3'd0;
        case (r_op)
            OP_READ: begin
                n_out_rdata = rd_val;
                n_out_oor   = oor;
            end
            OP_WRITE: begin
                n_out_oor = oor;
                if (!oor && r_idx == IDX_CTRL) begin
                    n_out_mapped = n_ctrl[BIT_PROG] | n_ctrl[BIT_MAP];
                end
            end
            OP_TICK: begin
                if (r_wd_armed && r_wd_count <= 32'd1 && !ctrl[BIT_STOP]) begin
                    n_out_mapped = 1'b0;
                    n_out_reboot = 1'b1;
                end
            end
            OP_DECODE: begin
                n_out_hit = r_hit;
                n_out_csi = r_hit ? 3'(r_cs) : 3'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            for (int i = 0; i < NREGS; i++) begin
                r_rf[i] <= RSTVAL[i];
            end
            r_devices    <= 8'd0;
            r_wd_ticks   <= WD_TICKS_RESET;
            r_wd_count   <= WD_TICKS_RESET;
            r_wd_armed   <= 1'b0;
            r_mapped     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_op         <= OP_READ;
            r_cs         <= '0;
            r_hit        <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_BOOT_DEV: begin
                        r_wd_count     <= r_wd_ticks;
                        r_mapped       <= i_cfg.data[0];
                        r_wd_armed     <= i_cfg.data[0];
                        r_rf[IDX_CTRL] <= n_strap_ctrl;
                    end
                    CFG_DEVICES: r_devices <= i_cfg.data[7:0];
                    CFG_WD_TICKS: r_wd_ticks <= i_cfg.data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= t_opcode'(i_req.opcode);
                        r_idx   <= i_req.reg_addr[6:3];
                        r_upper <= i_req.reg_addr[2];
                        r_word  <= i_req.word_access;
                        r_wdata <= i_req.write_data;
                        r_oaddr <= i_req.outer_addr;
                        r_cs    <= '0;
                        r_hit   <= 1'b0;
                        r_state <= (t_opcode'(i_req.opcode) == OP_DECODE) ? S_DECODE
                                                                          : S_FINISH;
                    end
                end
                S_DECODE: begin
                    if (cs_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FINISH;
                    end else if (r_cs == CS_W'(CHIP_SELECTS - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_cs <= r_cs + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_rdata  <= n_out_rdata;
                        r_out_oor    <= n_out_oor;
                        r_out_mapped <= n_out_mapped;
                        r_out_reboot <= n_out_reboot;
                        r_out_hit    <= n_out_hit;
                        r_out_csi    <= n_out_csi;
                        r_state      <= S_IDLE;
                        case (r_op)
                            OP_WRITE: begin
                                if (!oor) begin
                                    if (r_idx == IDX_CTRL) begin
                                        r_rf[r_idx] <= n_ctrl;
                                        r_mapped    <= n_ctrl[BIT_PROG] | n_ctrl[BIT_MAP];
                                    end else begin
                                        r_rf[r_idx] <= n_reg;
                                    end
                                end
                            end
                            OP_TICK: begin
                                if (r_wd_armed) begin
                                    if (r_wd_count > 32'd1) begin
                                        r_wd_count <= r_wd_count - 32'd1;
                                    end else begin
                                        r_wd_count <= 32'd0;
                                        r_wd_armed <= 1'b0;
                                        if (!ctrl[BIT_STOP]) begin
                                            r_rf[IDX_CTRL] <= n_tick_ctrl;
                                            r_mapped       <= 1'b0;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/dbc_checker.sv
// Port-level assertion checker for the device-bus controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_read_data,
    input logic        i_out_of_range,
    input logic        i_boot_map_enabled,
    input logic        i_reboot_request,
    input logic        i_cs_hit,
    input logic [2:0]  i_cs_index
);

    `DBC_ASSERT_NXT(a_rsp_held, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped while stalled")
    `DBC_ASSERT_IMP(a_oor_data, i_clk, i_rst_n, i_rsp_valid && i_out_of_range, (i_read_data == '1) || (i_read_data == '0), "out-of-range response carries register data")
    `DBC_ASSERT_IMP(a_reboot_unmap, i_clk, i_rst_n, i_rsp_valid && i_reboot_request, !i_boot_map_enabled, "reboot request with boot alias still mapped")
    `DBC_ASSERT_IMP(a_miss_index, i_clk, i_rst_n, i_rsp_valid && !i_cs_hit, i_cs_index == 3'd0, "decode miss reports a chip select")

endmodule

bind device_bus_controller_regs dbc_checker u_dbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_read_data       (o_rsp.read_data),
    .i_out_of_range    (o_rsp.out_of_range),
    .i_boot_map_enabled(o_rsp.boot_map_enabled),
    .i_reboot_request  (o_rsp.reboot_request),
    .i_cs_hit          (o_rsp.cs_hit),
    .i_cs_index        (o_rsp.cs_index)
);

>>> tb/sv/tb_device_bus_controller_regs.sv
// Self-checking testbench for the device-bus controller register block.
`timescale 1ns / 1ps
module tb_device_bus_controller_regs;
    import dbc_pkg::*;

    localparam int RUN_LIMIT = 500000;
    localparam int CHUNK = 50;
    localparam int N_CHUNKS = 33;
    localparam int MAX_IDLE = 13;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_MAX = 10;
    // Index three addresses no register and is ignored by the block.
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [63:0] M_BOOTROM = 64'd1 << BIT_BOOTROM;
    localparam logic [63:0] M_MAP = 64'd1 << BIT_MAP;

    typedef struct {
        t_opcode     op;
        logic [6:0]  addr;
        logic [63:0] wdata;
        logic        word;
        logic [28:0] oaddr;
    } bus_req_t;

    typedef struct {
        logic [63:0] read_data;
        logic        out_of_range;
        logic        boot_map_enabled;
        logic        reboot_request;
        logic        cs_hit;
        logic [2:0]  cs_index;
    } bus_rsp_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_index;
        logic [31:0] cfg_data;
        bus_req_t    req;
        bit          typed;
        bus_rsp_t    rsp;
    } step_row_t;

    logic i_clk;
    logic i_rst_n;

    dbc_cfg_if cfg_bus();
    dbc_req_if req_bus();
    dbc_rsp_if rsp_bus();

    device_bus_controller_regs DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    logic [63:0] reg_copy [NREGS];
    logic [31:0] wd_count;
    logic        wd_armed;
    logic        alias_on;
    logic [7:0]  dev_mask;
    logic [31:0] wd_length;

    bus_rsp_t  due_responses [$];
    step_row_t dir_rows [$];
    int        n_fail = 0;
    int        n_results = 0;
    bit        idle_on = 1'b1;
    bit        hold_long = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic void reset_copy();
        for (int i = 0; i < NREGS; i++) reg_copy[i] = RSTVAL[i];
        dev_mask = '0;
        wd_length = WD_TICKS_RESET;
        wd_count = wd_length;
        wd_armed = 1'b0;
        alias_on = 1'b0;
    endfunction

    function automatic void strap_config(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_BOOT_DEV: begin
                if (val[0]) begin
                    reg_copy[IDX_CTRL] = reg_copy[IDX_CTRL] | M_BOOTROM | M_MAP;
                    alias_on = 1'b1;
                    wd_armed = 1'b1;
                end else begin
                    reg_copy[IDX_CTRL] = reg_copy[IDX_CTRL] & ~M_BOOTROM;
                    alias_on = 1'b0;
                    wd_armed = 1'b0;
                end
                wd_count = wd_length;
            end
            CFG_DEVICES: dev_mask = val[7:0];
            CFG_WD_TICKS: wd_length = val;
            default: ;
        endcase
    endfunction

    function automatic logic [3:0] find_window(input logic [28:0] a);
        logic [63:0] win;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] t;
        logic [63:0] span;
        logic [63:0] pos;
        pos = 64'(a);
        for (int n = 0; n < CHIP_SELECTS; n++) begin
            win = reg_copy[int'(IDX_WIN) + n / 2] >> (32 * (n % 2));
            lo = 64'(win[12:0]) << 16;
            hi = 64'(win[28:16]) << 16;
            if (dev_mask[n] && hi >= lo) begin
                t = lo | hi | 64'h2000_0000;
                span = t & (~t + 64'd1);
                if (pos >= lo && pos - lo < span) return {1'b1, 3'(n)};
            end
        end
        return 4'd0;
    endfunction

    function automatic bus_rsp_t calc_response(input bus_req_t r);
        bus_rsp_t    res;
        logic [3:0]  idx;
        logic [63:0] cur;
        logic [63:0] val;
        logic [3:0]  sel;
        res = '{default: '0};
        idx = r.addr[6:3];
        case (r.op)
            OP_READ: begin
                if (int'(idx) >= NREGS) begin
                    res.out_of_range = 1'b1;
                    res.read_data = '1;
                end else begin
                    cur = reg_copy[idx];
                    if (r.word) cur = r.addr[2] ? {32'd0, cur[63:32]} : {32'd0, cur[31:0]};
                    res.read_data = cur;
                end
            end
            OP_WRITE: begin
                if (int'(idx) >= NREGS) begin
                    res.out_of_range = 1'b1;
                end else begin
                    cur = reg_copy[idx];
                    val = r.wdata;
                    if (r.word) begin
                        val = r.addr[2] ? {r.wdata[31:0], cur[31:0]}
                                        : {cur[63:32], r.wdata[31:0]};
                    end
                    cur = (cur & ~WMASK[idx]) | (val & WMASK[idx]);
                    if (idx == IDX_CTRL) begin
                        if (cur[BIT_BOOTROM]) begin
                            if (!val[BIT_MAP] && cur[BIT_STOP]) cur[BIT_MAP] = 1'b0;
                            if (val[BIT_STOP] && !cur[BIT_TIMEOUT]) cur[BIT_STOP] = 1'b1;
                        end
                        alias_on = cur[BIT_PROG] | cur[BIT_MAP];
                    end
                    reg_copy[idx] = cur;
                end
            end
            OP_TICK: begin
                if (wd_armed) begin
                    if (wd_count > 32'd1) begin
                        wd_count = wd_count - 32'd1;
                    end else begin
                        wd_count = '0;
                        wd_armed = 1'b0;
                        if (!reg_copy[IDX_CTRL][BIT_STOP]) begin
                            reg_copy[IDX_CTRL][BIT_MAP] = 1'b0;
                            reg_copy[IDX_CTRL][BIT_TIMEOUT] = 1'b1;
                            alias_on = 1'b0;
                            res.reboot_request = 1'b1;
                        end
                    end
                end
            end
            OP_DECODE: begin
                sel = find_window(r.oaddr);
                res.cs_hit = sel[3];
                res.cs_index = sel[2:0];
            end
            default: ;
        endcase
        res.boot_map_enabled = alias_on;
        return res;
    endfunction

    function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] data);
        step_row_t row;
        row.is_cfg = 1'b1;
        row.cfg_index = idx;
        row.cfg_data = data;
        row.req.op = OP_READ;
        row.req.addr = '0;
        row.req.wdata = '0;
        row.req.word = 1'b0;
        row.req.oaddr = '0;
        row.typed = 1'b0;
        row.rsp = '{default: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_req(input t_opcode op, input logic [6:0] addr,
                                    input logic [63:0] wdata, input logic word,
                                    input logic [28:0] oaddr);
        step_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_index = CFG_BOOT_DEV;
        row.cfg_data = '0;
        row.req.op = op;
        row.req.addr = addr;
        row.req.wdata = wdata;
        row.req.word = word;
        row.req.oaddr = oaddr;
        row.typed = 1'b0;
        row.rsp = '{default: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_known(input t_opcode op, input logic [6:0] addr,
                                      input logic [63:0] wdata, input logic word,
                                      input logic [28:0] oaddr, input logic [63:0] rd,
                                      input logic oor);
        step_row_t row;
        add_req(op, addr, wdata, word, oaddr);
        row = dir_rows.pop_back();
        row.typed = 1'b1;
        row.rsp.read_data = rd;
        row.rsp.out_of_range = oor;
        dir_rows.push_back(row);
    endfunction

    function automatic int draw_idle();
        return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic bus_req_t make_req();
        bus_req_t    r;
        int          pick;
        int          n;
        int          k;
        logic [63:0] win;
        logic [12:0] base13;
        logic [12:0] keep;
        pick = $urandom_range(0, 99);
        r.addr = 7'($urandom);
        r.wdata = {$urandom, $urandom};
        r.word = 1'($urandom);
        r.oaddr = 29'($urandom);
        if (pick < 20) begin
            r.op = OP_READ;
        end else if (pick < 45) begin
            r.op = OP_WRITE;
            case ($urandom_range(0, 3))
                0: r.addr[6:3] = IDX_CTRL;
                1: begin
                    r.addr[6:3] = 4'(int'(IDX_WIN) + $urandom_range(0, 3));
                    for (int h = 0; h < 2; h++) begin
                        k = $urandom_range(0, 13);
                        keep = ~13'((1 << k) - 1);
                        base13 = 13'($urandom) & keep;
                        r.wdata[32 * h +: 13] = base13;
                        r.wdata[32 * h + 16 +: 13] = base13 | (13'($urandom) & keep);
                    end
                end
                default: ;
            endcase
        end else if (pick < 70) begin
            r.op = OP_TICK;
        end else begin
            r.op = OP_DECODE;
            case ($urandom_range(0, 5))
                0: r.oaddr = '0;
                1: r.oaddr = '1;
                2, 3, 4: begin
                    n = $urandom_range(0, CHIP_SELECTS - 1);
                    win = reg_copy[int'(IDX_WIN) + n / 2] >> (32 * (n % 2));
                    r.oaddr = {win[12:0], 16'h0} + 29'($urandom_range(0, 32'h1FFFF));
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic send_req(input bus_req_t r, input bus_rsp_t known, input bit typed);
        bus_rsp_t want;
        int       gap;
        gap = draw_idle();
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid = 1'b1;
        req_bus.opcode = r.op;
        req_bus.reg_addr = r.addr;
        req_bus.write_data = r.wdata;
        req_bus.word_access = r.word;
        req_bus.outer_addr = r.oaddr;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        want = calc_response(r);
        if (typed) want = known;
        due_responses.push_back(want);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data = val;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        strap_config(idx, val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    initial begin
        bus_rsp_t got;
        bus_rsp_t want;
        int       stall;
        rsp_bus.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_long) begin
                stall = LONG_HOLD;
                hold_long = 1'b0;
            end else begin
                stall = draw_idle();
            end
            repeat (stall) begin
                @(negedge i_clk);
                rsp_bus.ready = 1'b0;
            end
            @(negedge i_clk);
            rsp_bus.ready = 1'b1;
            do @(posedge i_clk); while (rsp_bus.valid !== 1'b1);
            got.read_data = rsp_bus.read_data;
            got.out_of_range = rsp_bus.out_of_range;
            got.boot_map_enabled = rsp_bus.boot_map_enabled;
            got.reboot_request = rsp_bus.reboot_request;
            got.cs_hit = rsp_bus.cs_hit;
            got.cs_index = rsp_bus.cs_index;
            n_results++;
            if (due_responses.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_MAX)
                    $display("response %0d arrived with no request outstanding", n_results);
            end else begin
                want = due_responses.pop_front();
                if (got.read_data !== want.read_data
                        || got.out_of_range !== want.out_of_range
                        || got.boot_map_enabled !== want.boot_map_enabled
                        || got.reboot_request !== want.reboot_request
                        || got.cs_hit !== want.cs_hit
                        || got.cs_index !== want.cs_index) begin
                    n_fail++;
                    if (n_fail <= REPORT_MAX) begin
                        $display("response %0d expected: data %h oor %b map %b reboot %b hit %b cs %0d",
                                 n_results, want.read_data, want.out_of_range,
                                 want.boot_map_enabled, want.reboot_request, want.cs_hit,
                                 want.cs_index);
                        $display("response %0d actual:   data %h oor %b map %b reboot %b hit %b cs %0d",
                                 n_results, got.read_data, got.out_of_range,
                                 got.boot_map_enabled, got.reboot_request, got.cs_hit,
                                 got.cs_index);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("run timed out after %0d cycles", cycles);
        $display("FAIL device_bus_controller_regs");
        $finish;
    end

    initial begin
        bus_rsp_t   none;
        logic [1:0] cidx;
        logic [31:0] cval;
        none = '{default: '0};
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_BOOT_DEV;
        cfg_bus.data = '0;
        req_bus.valid = 1'b0;
        req_bus.opcode = OP_READ;
        req_bus.reg_addr = '0;
        req_bus.write_data = '0;
        req_bus.word_access = 1'b0;
        req_bus.outer_addr = '0;
        reset_copy();

        add_known(OP_READ, 7'h00, '0, 1'b0, '0, 64'h0000_0000_0000_0F00, 1'b0);
        add_known(OP_READ, 7'h7F, '0, 1'b1, '0, '1, 1'b1);
        add_known(OP_WRITE, 7'h78, '1, 1'b0, '0, '0, 1'b1);
        add_req(OP_WRITE, 7'h00, '1, 1'b0, '0);
        add_known(OP_READ, 7'h0C, '0, 1'b1, '0, '0, 1'b0);
        add_known(OP_READ, 7'h08, '0, 1'b1, '0, 64'h0000_0000_0202_0202, 1'b0);
        add_req(OP_WRITE, 7'h14, '1, 1'b0, '0);
        add_req(OP_READ, 7'h10, '0, 1'b0, '0);
        add_req(OP_WRITE, 7'h2C, 64'h0123_4567_89AB_CDEF, 1'b1, '0);
        add_req(OP_READ, 7'h28, '0, 1'b0, '0);
        add_known(OP_TICK, 7'h00, '0, 1'b0, '0, '0, 1'b0);
        add_known(OP_DECODE, 7'h00, '0, 1'b0, '0, '0, 1'b0);
        add_known(OP_DECODE, 7'h00, '0, 1'b0, '1, '0, 1'b0);
        add_req(OP_WRITE, 7'h50, '1, 1'b0, '0);
        add_req(OP_WRITE, 7'h50, '0, 1'b0, '0);
        add_cfg(CFG_DEVICES, 32'h0000_00FF);
        add_req(OP_WRITE, 7'h58, 64'h1FFF_0000_0010_0010, 1'b0, '0);
        add_req(OP_DECODE, 7'h00, '0, 1'b0, 29'h0010_0000);
        add_req(OP_DECODE, 7'h00, '0, 1'b0, '1);
        add_req(OP_DECODE, 7'h00, '0, 1'b0, '0);
        add_cfg(CFG_WD_TICKS, 32'd2);
        add_cfg(CFG_BOOT_DEV, 32'd1);
        add_req(OP_TICK, 7'h00, '0, 1'b0, '0);
        add_req(OP_TICK, 7'h00, '0, 1'b0, '0);
        add_req(OP_WRITE, 7'h54, 64'h0000_0000_0000_0001, 1'b1, '0);
        add_req(OP_READ, 7'h50, '0, 1'b0, '0);
        add_cfg(CFG_BOOT_DEV, 32'd0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_cfg(dir_rows[i].cfg_index, dir_rows[i].cfg_data);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].rsp, dir_rows[i].typed);
            end
        end

        for (int c = 0; c < N_CHUNKS; c++) begin
            drain();
            case (c)
                0: begin
                    write_cfg(CFG_DEVICES, 32'h0000_00FF);
                    write_cfg(CFG_WD_TICKS, 32'd1);
                    write_cfg(CFG_BOOT_DEV, 32'd1);
                end
                1: begin
                    write_cfg(CFG_DEVICES, 32'h0);
                    write_cfg(CFG_WD_TICKS, 32'hFFFF_FFFF);
                    write_cfg(CFG_BOOT_DEV, 32'hFFFF_FFFF);
                end
                2: begin
                    write_cfg(CFG_SPARE, $urandom);
                    write_cfg(CFG_BOOT_DEV, 32'hFFFF_FFFE);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        cidx = 2'($urandom_range(0, 3));
                        case (cidx)
                            CFG_BOOT_DEV: begin
                                cval = $urandom;
                                cval[0] = ($urandom_range(0, 3) != 0);
                            end
                            CFG_WD_TICKS: begin
                                cval = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF
                                                                   : 32'($urandom_range(1, 40));
                            end
                            default: cval = $urandom;
                        endcase
                        write_cfg(cidx, cval);
                    end
                end
            endcase
            idle_on = ($urandom_range(0, 3) != 0);
            // The receiver stops taking responses for a while, so requests back up.
            if (c == 5) begin
                idle_on = 1'b0;
                hold_long = 1'b1;
            end
            for (int k = 0; k < CHUNK; k++) begin
                if (c == 9 && k == CHUNK / 2) drain();
                send_req(make_req(), none, 1'b0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        n_fail += due_responses.size();
        if (n_fail == 0) begin
            $display("PASS device_bus_controller_regs");
        end else begin
            $display("FAIL device_bus_controller_regs");
        end
        $finish;
    end

endmodule
